// ----- sv/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/epid_pkg.sv -----
package epid_pkg;

    // Item tags, assembled as group then element
    localparam logic [31:0] TAG_ITEM      = 32'hFFFEE000;
    localparam logic [31:0] TAG_SEQ_DELIM = 32'hFFFEE0DD;

    // Marker pair that closes a frame
    localparam logic [7:0] MARK_HI = 8'hFF;
    localparam logic [7:0] MARK_LO = 8'hD9;

    // Header size in bytes from the sequence start
    localparam logic [31:0] HEADER_BYTES = 32'd8;

    localparam logic [15:0] FRAME_MAX = 16'hFFFF;

    // Record kinds
    localparam logic [1:0] KIND_TABLE   = 2'd0;
    localparam logic [1:0] KIND_FRAG    = 2'd1;
    localparam logic [1:0] KIND_DELIM   = 2'd2;
    localparam logic [1:0] KIND_BAD_TAG = 2'd3;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [15:0] frame_index;
        logic [31:0] value_offset;
        logic [31:0] value_length;
        logic        ends_frame;
    } result_t;

endpackage

// ----- sv/encapsulated_pixel_item_deframer_core.sv -----
// Encapsulated pixel data deframer. Takes one byte of the item sequence per
// transfer and sustains one byte every clock while in_stall is low. Each
// byte passes through one registered step, so a record shows on the output
// in the cycle after the byte that completes it: the offset table and
// delimiter when their 8-byte header ends, a fragment when its last value
// byte arrives (or at its header if it is empty). value_offset counts from
// the sequence start, just past the header. A bad first tag gives a record
// of kind 3 and the block then drops every byte until reset. in_stall rises
// only while a record waits and the output side stalls.
module encapsulated_pixel_item_deframer_core
    import epid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  record_kind,
    output logic [15:0] frame_index,
    output logic [31:0] value_offset,
    output logic [31:0] value_length,
    output logic        ends_frame
);

    logic    accept;
    logic    res_valid;
    result_t res;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    epid_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = res_valid;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
            out_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign record_kind  = out_reg.record_kind;
    assign frame_index  = out_reg.frame_index;
    assign value_offset = out_reg.value_offset;
    assign value_length = out_reg.value_length;
    assign ends_frame   = out_reg.ends_frame;

endmodule

// ----- sv/epid_parser.sv -----
// Item header assembly and value scan, one byte per transfer.
module epid_parser
    import epid_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    output logic       res_valid,
    output result_t    res
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_TABLE  = 2'd1,
        PH_FRAG   = 2'd2,
        PH_HALT   = 2'd3
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [63:0] shift_reg, shift_next;
    logic [2:0]  count_reg, count_next;
    logic [31:0] remain_reg, remain_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] start_reg, start_next;
    logic        first_reg, first_next;
    logic        pff_reg, pff_next;
    logic        marker_reg, marker_next;
    logic [15:0] frame_reg, frame_next;

    logic [63:0] shift_base;
    logic [31:0] tag;
    logic [31:0] len;

    assign shift_base = (count_reg == 3'd0) ? 64'd0 : shift_reg;
    // tag and length of the header that the eighth byte completes
    assign tag = {shift_reg[15:8], shift_reg[7:0], shift_reg[31:24], shift_reg[23:16]};
    assign len = {data_byte, shift_reg[55:32]};

    // Next state and result for the byte in transfer
    always_comb
    begin
        phase_next  = phase_reg;
        shift_next  = shift_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        first_next  = first_reg;
        pff_next    = pff_reg;
        marker_next = marker_reg;
        frame_next  = frame_reg;
        res_valid   = 1'b0;
        res.record_kind = KIND_FRAG;
        res.frame_index = 16'd0;
        res.ends_frame  = 1'b0;

        if (accept && phase_reg != PH_HALT)
        begin
            pos_next = pos_reg + 32'd1;
            case (phase_reg)
                PH_TABLE, PH_FRAG:
                begin
                    if (phase_reg == PH_FRAG)
                    begin
                        marker_next = marker_reg | (pff_reg && data_byte == MARK_LO);
                        pff_next    = (data_byte == MARK_HI);
                    end
                    remain_next = remain_reg - 32'd1;
                    if (remain_next == 32'd0)
                    begin
                        phase_next = PH_HEADER;
                        if (phase_reg == PH_FRAG)
                        begin
                            // last value byte closes the fragment
                            res_valid       = 1'b1;
                            res.record_kind = KIND_FRAG;
                            res.frame_index = frame_reg;
                            res.ends_frame  = marker_next;
                            if (marker_next && frame_reg != FRAME_MAX)
                                frame_next = frame_reg + 16'd1;
                            marker_next = 1'b0;
                            pff_next    = 1'b0;
                        end
                    end
                end
                PH_HEADER:
                begin
                    shift_next = shift_base | ({56'd0, data_byte} << {count_reg, 3'b000});
                    count_next = count_reg + 3'd1;
                    if (count_reg == 3'd7)
                    begin
                        start_next = pos_next;
                        res_valid  = 1'b1;
                        if (!first_reg)
                        begin
                            if (tag != TAG_ITEM)
                            begin
                                res.record_kind = KIND_BAD_TAG;
                                phase_next      = PH_HALT;
                            end
                            else
                            begin
                                res.record_kind = KIND_TABLE;
                                first_next      = 1'b1;
                                if (len != 32'd0)
                                begin
                                    remain_next = len;
                                    phase_next  = PH_TABLE;
                                end
                            end
                        end
                        else if (tag == TAG_SEQ_DELIM)
                        begin
                            // end of sequence, counters restart
                            res.record_kind = KIND_DELIM;
                            pos_next    = 32'd0;
                            frame_next  = 16'd0;
                            first_next  = 1'b0;
                            pff_next    = 1'b0;
                            marker_next = 1'b0;
                        end
                        else
                        begin
                            pff_next    = 1'b0;
                            marker_next = 1'b0;
                            if (len == 32'd0)
                            begin
                                // empty fragment reported at once
                                res.record_kind = KIND_FRAG;
                                res.frame_index = frame_reg;
                            end
                            else
                            begin
                                res_valid   = 1'b0;
                                remain_next = len;
                                phase_next  = PH_FRAG;
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        res.value_offset = start_next;
        res.value_length = shift_next[63:32];
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            shift_reg  <= 64'd0;
            count_reg  <= 3'd0;
            remain_reg <= 32'd0;
            pos_reg    <= 32'd0;
            start_reg  <= 32'd0;
            first_reg  <= 1'b0;
            pff_reg    <= 1'b0;
            marker_reg <= 1'b0;
            frame_reg  <= 16'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            shift_reg  <= shift_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            first_reg  <= first_next;
            pff_reg    <= pff_next;
            marker_reg <= marker_next;
            frame_reg  <= frame_next;
        end
    end

endmodule

// ----- sv/epid_checker.sv -----
`include "assert_macros.svh"

// Port-level checks on the deframer
module epid_checker
    import epid_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  data_byte,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  record_kind,
    input logic [15:0] frame_index,
    input logic [31:0] value_offset,
    input logic [31:0] value_length,
    input logic        ends_frame
);

    logic in_xfer;
    assign in_xfer = in_valid && !in_stall && (data_byte == data_byte);

    // a waiting record holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(record_kind) && $stable(frame_index) && $stable(value_offset) && $stable(value_length) && $stable(ends_frame), "stalled record changed")

    // input backs up only behind a stalled record
    `ASSERT_SAME(a_in_stall, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without a waiting record")

    // frame fields only on fragments
    `ASSERT_SAME(a_frag_fields, clk, rst_n, out_valid && record_kind != KIND_FRAG, frame_index == 16'd0 && !ends_frame, "frame fields set on a non-fragment record")

    // first item of a sequence always starts right after its header
    `ASSERT_SAME(a_first_offset, clk, rst_n, out_valid && (record_kind == KIND_TABLE || record_kind == KIND_BAD_TAG), value_offset == HEADER_BYTES, "first item offset wrong")

    // a new record needs a byte transfer in the cycle before
    `ASSERT_SAME(a_rec_cause, clk, rst_n, out_valid && !$past(out_valid && out_stall), $past(in_xfer), "record without an input transfer")

endmodule

bind encapsulated_pixel_item_deframer_core epid_checker u_epid_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .record_kind  (record_kind),
    .frame_index  (frame_index),
    .value_offset (value_offset),
    .value_length (value_length),
    .ends_frame   (ends_frame)
);

// ----- tb/sv/encapsulated_pixel_item_deframer_core_test.sv -----
module encapsulated_pixel_item_deframer_core_test;
    import epid_pkg::*;

    // Parser position within the item stream
    typedef enum logic [1:0] {
        SCAN_HEADER,
        SKIP_TABLE,
        SCAN_FRAGMENT,
        HALTED
    } scan_phase_t;

    // Tracks the item stream byte by byte and holds the records it should produce
    class item_record_ledger;
        result_t     awaited_records[$];
        int          mismatches;
        int          records_matched;
        scan_phase_t phase;
        logic [63:0] header_shift;
        logic [2:0]  header_count;
        logic [31:0] value_remaining;
        logic [31:0] byte_position;
        logic [31:0] value_start;
        bit          first_item_done;
        bit          previous_was_ff;
        bit          marker_seen;
        logic [15:0] frame_counter;

        function void clear();
            awaited_records.delete();
            mismatches = 0;
            records_matched = 0;
            phase = SCAN_HEADER;
            header_shift = '0;
            header_count = '0;
            value_remaining = '0;
            byte_position = '0;
            value_start = '0;
            first_item_done = 0;
            previous_was_ff = 0;
            marker_seen = 0;
            frame_counter = '0;
        endfunction

        function void post(logic [1:0] kind, logic [15:0] frame, logic ends);
            result_t rec;
            rec.record_kind  = kind;
            rec.frame_index  = frame;
            rec.value_offset = value_start;
            rec.value_length = header_shift[63:32];
            rec.ends_frame   = ends;
            awaited_records = {awaited_records, rec};
        endfunction

        function void close_fragment();
            post(KIND_FRAG, frame_counter, marker_seen);
            if (marker_seen && frame_counter != FRAME_MAX)
                frame_counter++;
            marker_seen = 0;
            previous_was_ff = 0;
            phase = SCAN_HEADER;
        endfunction

        // One accepted byte of the stream
        function void take_byte(logic [7:0] b);
            logic [31:0] tag;
            logic [31:0] len;
            if (phase == HALTED)
                return;
            byte_position++;

            // Value bytes: table is skipped, fragment is scanned for the marker pair
            if (phase == SKIP_TABLE || phase == SCAN_FRAGMENT)
            begin
                if (phase == SCAN_FRAGMENT)
                begin
                    if (previous_was_ff && b == MARK_LO)
                        marker_seen = 1;
                    previous_was_ff = (b == MARK_HI);
                end
                value_remaining--;
                if (value_remaining != 0)
                    return;
                if (phase == SKIP_TABLE)
                    phase = SCAN_HEADER;
                else
                    close_fragment();
                return;
            end

            // Header assembly
            if (header_count == 0)
                header_shift = '0;
            header_shift[8 * header_count +: 8] = b;
            header_count++;
            if (header_count != 0)
                return;

            value_start = byte_position;
            tag = {header_shift[15:8], header_shift[7:0], header_shift[31:24], header_shift[23:16]};
            len = header_shift[63:32];

            if (!first_item_done)
            begin
                if (tag != TAG_ITEM)
                begin
                    post(KIND_BAD_TAG, '0, 1'b0);
                    phase = HALTED;
                    return;
                end
                first_item_done = 1;
                post(KIND_TABLE, '0, 1'b0);
                if (len != 0)
                begin
                    value_remaining = len;
                    phase = SKIP_TABLE;
                end
                return;
            end

            if (tag == TAG_SEQ_DELIM)
            begin
                post(KIND_DELIM, '0, 1'b0);
                byte_position = '0;
                frame_counter = '0;
                first_item_done = 0;
                previous_was_ff = 0;
                marker_seen = 0;
                phase = SCAN_HEADER;
                return;
            end

            // Any other tag is a fragment
            previous_was_ff = 0;
            marker_seen = 0;
            if (len == 0)
            begin
                close_fragment();
                return;
            end
            value_remaining = len;
            phase = SCAN_FRAGMENT;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        // One accepted record against the oldest awaited one
        function void match_record(result_t got);
            result_t want;
            records_matched++;
            if (awaited_records.size() == 0)
            begin
                $display("%0t: unexpected record, expected none, actual kind %0d offset 0x%0h length 0x%0h",
                         $time, got.record_kind, got.value_offset, got.value_length);
                mismatches++;
                return;
            end
            want = awaited_records.pop_front();
            compare_field("record_kind", want.record_kind, got.record_kind);
            compare_field("frame_index", want.frame_index, got.frame_index);
            compare_field("value_offset", want.value_offset, got.value_offset);
            compare_field("value_length", want.value_length, got.value_length);
            compare_field("ends_frame", want.ends_frame, got.ends_frame);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  record_kind;
    logic [15:0] frame_index;
    logic [31:0] value_offset;
    logic [31:0] value_length;
    logic        ends_frame;

    item_record_ledger ledger;
    int                in_gap_max;
    int                out_gap_max;
    int                bytes_sent;
    bit                seq_open;

    encapsulated_pixel_item_deframer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .record_kind  (record_kind),
        .frame_index  (frame_index),
        .value_offset (value_offset),
        .value_length (value_length),
        .ends_frame   (ends_frame)
    );

    always #10 clk = ~clk;

    // Observe transfers on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                ledger.take_byte(data_byte);
            if (out_valid && !out_stall)
                ledger.match_record(result_t'({record_kind, frame_index, value_offset,
                                               value_length, ends_frame}));
        end
    end

    // Output side: random stall before each record
    initial
    begin
        int n;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            n = $urandom_range(0, out_gap_max);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    function int pick_idle_span();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 4;
            default: return 14;
        endcase
    endfunction

    // Mostly marker bytes so pairs and split pairs show up often
    function logic [7:0] pick_value_byte();
        case ($urandom_range(0, 3))
            0: return MARK_HI;
            1: return MARK_LO;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic drive_byte(input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    // Tag goes out group LE then element LE, length LE
    task automatic drive_header(input logic [31:0] tag, input logic [31:0] len);
        drive_byte(tag[23:16]);
        drive_byte(tag[31:24]);
        drive_byte(tag[7:0]);
        drive_byte(tag[15:8]);
        drive_byte(len[7:0]);
        drive_byte(len[15:8]);
        drive_byte(len[23:16]);
        drive_byte(len[31:24]);
    endtask

    // Hold the input until every awaited record has been taken
    task automatic drain_records();
        in_valid <= 1'b0;
        do @(negedge clk); while (ledger.awaited_records.size() != 0);
        @(posedge clk);
    endtask

    function logic [31:0] pick_delim_length();
        case ($urandom_range(0, 3))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Offset table, a few fragments, then usually a delimiter
    task automatic drive_random_sequence();
        int          n_frag;
        int          len;
        logic [31:0] tag;
        in_gap_max  = pick_idle_span();
        out_gap_max = pick_idle_span();
        len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        drive_header(TAG_ITEM, len);
        repeat (len) drive_byte(8'($urandom_range(0, 255)));
        seq_open = 1;
        n_frag = $urandom_range(1, 5);
        repeat (n_frag)
        begin
            tag = TAG_ITEM;
            if ($urandom_range(0, 5) == 0)
            begin
                tag = $urandom;
                if (tag == TAG_SEQ_DELIM)
                    tag = TAG_ITEM;
            end
            len = $urandom_range(0, 12);
            drive_header(tag, len);
            repeat (len) drive_byte(pick_value_byte());
        end
        // A missing delimiter turns the next table into a fragment
        if ($urandom_range(0, 7) != 0)
        begin
            drive_header(TAG_SEQ_DELIM, pick_delim_length());
            seq_open = 0;
        end
        if ($urandom_range(0, 9) == 0)
            drain_records();
    endtask

    // Run limit
    initial
    begin
        #2_000_000;
        $display("encapsulated_pixel_item_deframer_core_test failed");
        $finish;
    end

    initial
    begin
        logic [31:0] bad_tag;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        data_byte   = 8'h00;
        in_gap_max  = 3;
        out_gap_max = 3;
        bytes_sent  = 0;
        seq_open    = 0;
        ledger = new;
        ledger.clear();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, closing fragment, split marker, empty fragment
        drive_header(TAG_ITEM, 32'd0);
        drive_header(TAG_ITEM, 32'd2);
        drive_byte(MARK_HI);
        drive_byte(MARK_LO);
        drive_header(32'h1234_5678, 32'd2);
        drive_byte(8'h00);
        drive_byte(MARK_HI);
        drive_header(TAG_ITEM, 32'd1);
        drive_byte(MARK_LO);
        drive_header(TAG_ITEM, 32'd0);
        drive_header(TAG_SEQ_DELIM, 32'hFFFF_FFFF);
        drain_records();

        // Random sequences
        while (bytes_sent < 440)
            drive_random_sequence();
        if (seq_open)
            drive_header(TAG_SEQ_DELIM, 32'd0);
        drain_records();

        // Counters start over after the delimiter
        drive_random_sequence();
        if (seq_open)
            drive_header(TAG_SEQ_DELIM, 32'd0);

        // Bad first tag halts the block; later bytes are dropped
        in_gap_max  = 14;
        out_gap_max = 14;
        bad_tag = TAG_SEQ_DELIM;
        if ($urandom_range(0, 1) == 0)
        begin
            bad_tag = $urandom;
            if (bad_tag == TAG_ITEM)
                bad_tag = TAG_SEQ_DELIM;
        end
        drive_header(bad_tag, $urandom);
        repeat (12) drive_byte(8'($urandom_range(0, 255)));

        drain_records();
        repeat (20) @(posedge clk);
        if (ledger.mismatches == 0)
            $display("encapsulated_pixel_item_deframer_core_test passed");
        else
            $display("encapsulated_pixel_item_deframer_core_test failed");
        $finish;
    end

endmodule
